// ===== rtl/egp_pkg.sv =====
// Shared constants for the Elias-gamma triple packer.
`timescale 1ns / 1ps

package egp_pkg;

  // Default width of each coded value.
  localparam int unsigned VALUE_BITS_DEF = 31;

  // Bits in one output byte.
  localparam int unsigned BYTE_BITS = 8;

  // Marker ORed into the first byte of a run that carries the term code.
  localparam logic [BYTE_BITS-1:0] TERM_MARK = 8'h80;

  // Number of values coded per item.
  localparam int unsigned NUM_VALUES = 3;

endpackage

// ===== rtl/egp_code.sv =====
// Builds the stream-ordered gamma code and its length for one value.
`timescale 1ns / 1ps

module egp_code import egp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0]                   value_i,
  input  logic [$clog2(VALUE_BITS)-1:0]           lead_i,
  output logic [2*VALUE_BITS-2:0]                 code_o,
  output logic [$clog2(2*VALUE_BITS)-1:0]         len_o
);

  localparam int unsigned NW  = $clog2(VALUE_BITS);
  localparam int unsigned MCB = 2 * VALUE_BITS - 1;
  localparam int unsigned LW  = $clog2(MCB + 1);
  localparam logic [NW:0] VB_L = (NW + 1)'(VALUE_BITS);

  logic [VALUE_BITS-1:0] rev;
  logic [NW:0]           rsh;
  logic [LW-1:0]         lead_l;
  logic [MCB-1:0]        ones;
  logic [MCB-1:0]        rest;
  logic                  big;

  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      rev[VALUE_BITS-1-i] = value_i[i];
    end
  end

  // Values above one have a nonzero leading-one position.
  assign big    = (lead_i != '0);
  assign lead_l = LW'(lead_i);
  assign rsh    = VB_L - {1'b0, lead_i};

  // Unary prefix of n ones, then the n low bits in emission order after the zero.
  assign ones = (MCB'(1) << lead_i) - MCB'(1);
  assign rest = MCB'(rev >> rsh) << (lead_l + LW'(1));

  assign code_o = big ? (ones | rest) : (MCB'(value_i[0]) << 1);
  assign len_o  = big ? ((lead_l << 1) + LW'(1)) : LW'(2);

endmodule

// ===== rtl/egp_serializer.sv =====
// Byte serializer: holds one packed run and sends it a byte per transfer.
`timescale 1ns / 1ps

module egp_serializer import egp_pkg::*; #(
  parameter int unsigned WORD_BITS = 184,
  parameter int unsigned CNT_W     = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_valid_i,
  output logic                  load_ready_o,
  input  logic [WORD_BITS-1:0]  load_word_i,
  input  logic [CNT_W-1:0]      load_bytes_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_BITS-1:0]  out_byte_o,
  output logic                  last_byte_o
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 xfer;
  logic                 load;

  assign out_valid_o  = (cnt_q != '0);
  assign last_byte_o  = (cnt_q == CNT_W'(1));
  assign out_byte_o   = word_q[BYTE_BITS-1:0];
  assign xfer         = out_valid_o && out_ready_i;
  // Take the next run when empty or as the final byte leaves.
  assign load_ready_o = !out_valid_o || (xfer && last_byte_o);
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    if (load) begin
      word_d = load_word_i;
      cnt_d  = load_bytes_i;
    end else if (xfer) begin
      word_d = word_q >> BYTE_BITS;
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ===== rtl/elias_gamma_triple_packer.sv =====
// Top level of the Elias-gamma triple packer: code pipeline and byte output.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) moves one item per transfer: three
//   values and the write_term flag. Output channel (out_valid_o / out_ready_i)
//   moves one packed byte per transfer; last_byte_o marks the final byte of an
//   item's run. A run is 1 to MAXB bytes (23 at VALUE_BITS = 31).
//   Path: an item passes five register stages (input, leading-one position,
//   code build, first merge, final merge) and then loads into the serializer,
//   which offers its first byte when the output side is free.
//   Throughput: the serializer's single byte port sends one byte per transfer,
//   so an item holds the output for as many transfers as its run has bytes;
//   an input transfer can happen every cycle while the pipeline has room, and
//   the next run loads in the same cycle as the previous run's last byte leaves.
//   Reset (rst_ni low, asynchronous) drops every item in flight and empties
//   the serializer; the block holds no other state.
//   When the receiver stalls, the current byte holds on the port, the
//   pipeline fills up stage by stage, and then in_ready_o drops; nothing is
//   lost or repeated.

module elias_gamma_triple_packer import egp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] term_value_i,
  input  logic [VALUE_BITS-1:0] doc_value_i,
  input  logic [VALUE_BITS-1:0] count_value_i,
  input  logic                  write_term_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_BITS-1:0]  out_byte_o,
  output logic                  last_byte_o
);

  localparam int unsigned NW   = $clog2(VALUE_BITS);
  localparam int unsigned MCB  = 2 * VALUE_BITS - 1;
  localparam int unsigned LW   = $clog2(MCB + 1);
  localparam int unsigned ABW  = 2 * MCB;
  localparam int unsigned LABW = $clog2(ABW + 1);
  localparam int unsigned TB   = 3 * MCB;
  localparam int unsigned TW   = $clog2(TB + 1);
  localparam int unsigned MAXB = (TB + BYTE_BITS - 1) / BYTE_BITS;
  localparam int unsigned WB   = MAXB * BYTE_BITS;
  localparam int unsigned CW   = $clog2(MAXB + 1);
  localparam int unsigned BSH  = $clog2(BYTE_BITS);

  // Stage 1: registered input item.
  logic                  s1_v_q;
  logic [VALUE_BITS-1:0] s1_val_q [NUM_VALUES];
  logic                  s1_term_q;

  // Stage 2: leading-one position of each value.
  logic                  s2_v_q;
  logic [VALUE_BITS-1:0] s2_val_q [NUM_VALUES];
  logic [NW-1:0]         s2_lead_q [NUM_VALUES];
  logic [NW-1:0]         s2_lead_d [NUM_VALUES];
  logic                  s2_term_q;

  // Stage 3: stream-ordered code and length of each value.
  logic                  s3_v_q;
  logic [MCB-1:0]        s3_code_q [NUM_VALUES];
  logic [LW-1:0]         s3_len_q [NUM_VALUES];
  logic [MCB-1:0]        s3_code_d [NUM_VALUES];
  logic [LW-1:0]         s3_len_d [NUM_VALUES];
  logic                  s3_term_q;

  // Stage 4: term and doc codes merged.
  logic                  s4_v_q;
  logic [ABW-1:0]        s4_ab_q, s4_ab_d;
  logic [LABW-1:0]       s4_lab_q, s4_lab_d;
  logic [MCB-1:0]        s4_c_q;
  logic [LW-1:0]         s4_lc_q;
  logic                  s4_term_q;

  // Stage 5: full packed run and its byte count.
  logic                  s5_v_q;
  logic [WB-1:0]         s5_word_q, s5_word_d;
  logic [CW-1:0]         s5_bytes_q, s5_bytes_d;
  logic [TW-1:0]         s5_total;
  logic                  s5_term_q;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ser_ready;

  // Advance a stage when it is empty or its successor takes its item.
  assign rdy5 = !s5_v_q || ser_ready;
  assign rdy4 = !s4_v_q || rdy5;
  assign rdy3 = !s3_v_q || rdy4;
  assign rdy2 = !s2_v_q || rdy3;
  assign rdy1 = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;

  // Leading-one position; zero for values 0 and 1.
  always_comb begin
    for (int k = 0; k < NUM_VALUES; k++) begin
      s2_lead_d[k] = '0;
      for (int i = 1; i < VALUE_BITS; i++) begin
        if (s1_val_q[k][i]) begin
          s2_lead_d[k] = NW'(i);
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_VALUES; g++) begin : g_code
    egp_code #(
      .VALUE_BITS(VALUE_BITS)
    ) u_code (
      .value_i (s2_val_q[g]),
      .lead_i  (s2_lead_q[g]),
      .code_o  (s3_code_d[g]),
      .len_o   (s3_len_d[g])
    );
  end

  // Drop the term code entirely when the flag is clear.
  always_comb begin
    logic [MCB-1:0] t_code;
    logic [LW-1:0]  t_len;
    t_code   = s3_term_q ? s3_code_q[0] : '0;
    t_len    = s3_term_q ? s3_len_q[0] : '0;
    s4_ab_d  = ABW'(t_code) | (ABW'(s3_code_q[1]) << t_len);
    s4_lab_d = LABW'(t_len) + LABW'(s3_len_q[1]);
  end

  always_comb begin
    s5_word_d = WB'(s4_ab_q) | (WB'(s4_c_q) << s4_lab_q);
    if (s4_term_q) begin
      s5_word_d = s5_word_d | WB'(TERM_MARK);
    end
    s5_total   = TW'(s4_lab_q) + TW'(s4_lc_q);
    s5_bytes_d = CW'(((TW + 1)'(s5_total) + (TW + 1)'(BYTE_BITS - 1)) >> BSH);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
      if (rdy4) s4_v_q <= s3_v_q;
      if (rdy5) s5_v_q <= s4_v_q;
    end
  end

  // Payload; load only with a valid item coming in.
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_val_q[0] <= term_value_i;
      s1_val_q[1] <= doc_value_i;
      s1_val_q[2] <= count_value_i;
      s1_term_q   <= write_term_i;
    end
    if (rdy2 && s1_v_q) begin
      s2_val_q  <= s1_val_q;
      s2_lead_q <= s2_lead_d;
      s2_term_q <= s1_term_q;
    end
    if (rdy3 && s2_v_q) begin
      s3_code_q <= s3_code_d;
      s3_len_q  <= s3_len_d;
      s3_term_q <= s2_term_q;
    end
    if (rdy4 && s3_v_q) begin
      s4_ab_q   <= s4_ab_d;
      s4_lab_q  <= s4_lab_d;
      s4_c_q    <= s3_code_q[2];
      s4_lc_q   <= s3_len_q[2];
      s4_term_q <= s3_term_q;
    end
    if (rdy5 && s4_v_q) begin
      s5_word_q  <= s5_word_d;
      s5_bytes_q <= s5_bytes_d;
      s5_term_q  <= s4_term_q;
    end
  end

  egp_serializer #(
    .WORD_BITS(WB),
    .CNT_W    (CW)
  ) u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s5_v_q),
    .load_ready_o (ser_ready),
    .load_word_i  (s5_word_q),
    .load_bytes_i (s5_bytes_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

`ifndef SYNTH
  // A finished run always has between one and MAXB bytes.
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v_q |-> (s5_bytes_q != '0) && (s5_bytes_q <= CW'(MAXB)))
    else $error("packed run byte count out of range");

  // A run with the term code carries the marker in its first byte.
  a_term_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_v_q && s5_term_q) |-> s5_word_q[BYTE_BITS-1])
    else $error("term marker missing from first byte");

  // A stalled first merge stage keeps its item until the next stage takes it.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_v_q && !rdy5) |=> s4_v_q && $stable(s4_ab_q) && $stable(s4_lab_q))
    else $error("stalled merge stage lost its item");
`endif

endmodule
